>>> rtl/tcte_pkg.sv
`default_nettype none

package tcte_pkg;

  localparam int CFG_BITS   = 26;
  localparam int CFG_IDX_W  = 3;

  localparam logic [2:0] FUNC_TICK          = 3'd0;
  localparam logic [2:0] FUNC_ARM_TIMEWAIT  = 3'd1;
  localparam logic [2:0] FUNC_ARM_RETRANS   = 3'd2;
  localparam logic [2:0] FUNC_DISARM_RETRANS = 3'd3;
  localparam logic [2:0] FUNC_ACK_UPDATE    = 3'd4;
  localparam logic [2:0] FUNC_ARM_PERSIST   = 3'd5;
  localparam logic [2:0] FUNC_DISARM_PERSIST = 3'd6;

  localparam logic [1:0] RT_NONE   = 2'd0;
  localparam logic [1:0] RT_RESEND = 2'd1;
  localparam logic [1:0] RT_RESET  = 2'd2;
  localparam logic [1:0] RT_WAKE   = 2'd3;

  localparam logic [1:0] PS_NONE    = 2'd0;
  localparam logic [1:0] PS_PROBE   = 2'd1;
  localparam logic [1:0] PS_RELEASE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEWAIT_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RETRANS_INITIAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_INTERVAL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_LIMIT   = 3'd4;

  localparam logic [CFG_BITS-1:0] TIMEWAIT_LIMIT_RST  = 26'd2000000;
  localparam logic [CFG_BITS-1:0] RETRANS_INITIAL_RST = 26'd200000;
  localparam logic [CFG_BITS-1:0] SCAN_INTERVAL_RST   = 26'd10000;
  localparam logic [1:0]          MAX_RETRIES_RST     = 2'd3;
  localparam logic [15:0]         SEGMENT_LIMIT_RST   = 16'd1460;

  typedef struct packed {
    logic [CFG_BITS-1:0] timewait_limit;
    logic [CFG_BITS-1:0] retrans_initial;
    logic [CFG_BITS-1:0] scan_interval;
    logic [1:0]          max_retries;
    logic [15:0]         segment_size_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  conn;
    logic        send_buf_empty;
    logic        established;
    logic [15:0] send_window;
  } cmd_t;

  typedef struct packed {
    logic [3:0] conn_out;
    logic       timewait_closed;
    logic [1:0] retrans_action;
    logic [1:0] persist_action;
    logic [1:0] retry_count;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/tcte_table.sv
`default_nettype none

module tcte_table #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 83,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> rtl/tcte_update.sv
`default_nettype none

module tcte_update #(
  parameter int TIMER_BITS = 26
) (
  input  wire tcte_pkg::cfg_t              cfg,
  input  wire tcte_pkg::cmd_t              cmd,
  input  wire logic [3*TIMER_BITS+4:0]     entry,
  output logic      [3*TIMER_BITS+4:0]     entry_next,
  output tcte_pkg::result_t                res
);

  localparam int WW = ((TIMER_BITS > tcte_pkg::CFG_BITS) ? TIMER_BITS : tcte_pkg::CFG_BITS) + 1;
  localparam int PW = (WW > tcte_pkg::CFG_BITS + 3) ? WW : tcte_pkg::CFG_BITS + 3;
  localparam logic [PW-1:0] TMAX = PW'((64'd1 << TIMER_BITS) - 64'd1);

  logic                  tw_on, rt_on, ps_on;
  logic [TIMER_BITS-1:0] tw_el, rt_rem, ps_rem;
  logic [1:0]            rt_cnt;

  logic                  n_tw_on, n_rt_on, n_ps_on;
  logic [TIMER_BITS-1:0] n_tw_el, n_rt_rem, n_ps_rem;
  logic [1:0]            n_rt_cnt;

  logic                  closed;
  logic                  tw_closed;
  logic [1:0]            rt_act, ps_act;

  logic [WW-1:0]         scan_w;
  logic [WW-1:0]         el_sum;
  logic                  tw_expired;
  logic [TIMER_BITS-1:0] el_sat;
  logic [TIMER_BITS-1:0] rt_dn, ps_dn;
  logic [TIMER_BITS-1:0] init_sat;
  logic [1:0]            cnt_inc;
  logic [PW-1:0]         reload_prod;
  logic [TIMER_BITS-1:0] reload_sat;

  assign {tw_on, tw_el, rt_on, rt_rem, rt_cnt, ps_on, ps_rem} = entry;

  assign scan_w     = WW'(cfg.scan_interval);
  assign el_sum     = WW'(tw_el) + scan_w;
  assign tw_expired = WW'(tw_el) > WW'(cfg.timewait_limit);
  assign el_sat     = (PW'(el_sum) > TMAX) ? TIMER_BITS'(TMAX) : TIMER_BITS'(el_sum);
  assign rt_dn      = (WW'(rt_rem) > scan_w) ? TIMER_BITS'(WW'(rt_rem) - scan_w) : '0;
  assign ps_dn      = (WW'(ps_rem) > scan_w) ? TIMER_BITS'(WW'(ps_rem) - scan_w) : '0;
  assign init_sat   = (PW'(cfg.retrans_initial) > TMAX) ? TIMER_BITS'(TMAX)
                                                         : TIMER_BITS'(cfg.retrans_initial);
  assign cnt_inc     = rt_cnt + 2'd1;
  assign reload_prod = PW'(cfg.retrans_initial) * PW'({1'b0, cnt_inc} + 3'd1);
  assign reload_sat  = (reload_prod > TMAX) ? TIMER_BITS'(TMAX) : TIMER_BITS'(reload_prod);

  always_comb begin
    n_tw_on   = tw_on;
    n_tw_el   = tw_el;
    n_rt_on   = rt_on;
    n_rt_rem  = rt_rem;
    n_rt_cnt  = rt_cnt;
    n_ps_on   = ps_on;
    n_ps_rem  = ps_rem;
    closed    = 1'b0;
    tw_closed = 1'b0;
    rt_act    = tcte_pkg::RT_NONE;
    ps_act    = tcte_pkg::PS_NONE;
    unique case (cmd.func)
      tcte_pkg::FUNC_TICK: begin
        if (tw_on) begin
          if (tw_expired) begin
            n_tw_on   = 1'b0;
            n_rt_on   = 1'b0;
            closed    = 1'b1;
            tw_closed = 1'b1;
          end else begin
            n_tw_el = el_sat;
          end
        end
        if (n_rt_on) begin
          if (rt_rem != '0) begin
            n_rt_rem = rt_dn;
          end else if (rt_cnt >= cfg.max_retries) begin
            n_rt_on = 1'b0;
            closed  = 1'b1;
            rt_act  = tcte_pkg::RT_RESET;
          end else begin
            n_rt_cnt = cnt_inc;
            n_rt_rem = reload_sat;
            rt_act   = tcte_pkg::RT_RESEND;
          end
        end
        if (ps_on) begin
          if (ps_rem != '0) begin
            n_ps_rem = ps_dn;
          end else if (!cmd.established || closed) begin
            n_ps_on = 1'b0;
            ps_act  = tcte_pkg::PS_RELEASE;
          end else if (cmd.send_window < cfg.segment_size_limit) begin
            n_ps_rem = init_sat;
            ps_act   = tcte_pkg::PS_PROBE;
          end
        end
      end
      tcte_pkg::FUNC_ARM_TIMEWAIT: begin
        n_tw_on = 1'b1;
        n_tw_el = '0;
      end
      tcte_pkg::FUNC_ARM_RETRANS: begin
        if (!rt_on) begin
          n_rt_on  = 1'b1;
          n_rt_cnt = 2'd0;
        end
        n_rt_rem = init_sat;
      end
      tcte_pkg::FUNC_DISARM_RETRANS: begin
        n_rt_on = 1'b0;
      end
      tcte_pkg::FUNC_ACK_UPDATE: begin
        if (rt_on) begin
          if (cmd.send_buf_empty) begin
            n_rt_on = 1'b0;
            rt_act  = tcte_pkg::RT_WAKE;
          end else begin
            n_rt_rem = init_sat;
            n_rt_cnt = 2'd0;
          end
        end
      end
      tcte_pkg::FUNC_ARM_PERSIST: begin
        n_ps_on  = 1'b1;
        n_ps_rem = init_sat;
      end
      tcte_pkg::FUNC_DISARM_PERSIST: begin
        n_ps_on = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign entry_next = {n_tw_on, n_tw_el, n_rt_on, n_rt_rem, n_rt_cnt, n_ps_on, n_ps_rem};

  assign res.conn_out        = cmd.conn;
  assign res.timewait_closed = tw_closed;
  assign res.retrans_action  = rt_act;
  assign res.persist_action  = ps_act;
  assign res.retry_count     = n_rt_cnt;

endmodule

`default_nettype wire

>>> rtl/tcp_connection_timer_engine_unit.sv
// Per-connection timer engine for time-wait, retransmit and persist timers.
// Command channel: a word on cmd is taken at a clock edge with start high
// and busy low. func selects tick, arm, disarm or ack update for one
// connection. Every word yields exactly one result word.
// Result channel: done is high for one cycle with the result word on result;
// it is registered from the update stage. The receiver cannot stall.
// Throughput: one command per cycle while busy is low. The connection table
// sits in one synchronous memory (one read, one write port); each command
// reads its entry, updates it in the next cycle and writes it back; a
// command to the entry being written gets the new value by forwarding.
// Configuration: wr_en, wr_index and wr_data write one register at a clock
// edge; write only while no command is in flight.
// Reset: rst restores the register defaults and starts a clearing pass that
// zeroes the table, one entry a cycle, until every entry is clear; busy is
// high throughout and no command is taken.
// Commands beyond the table change nothing and report only their conn.
`default_nettype none

module tcp_connection_timer_engine_unit #(
  parameter int CONNECTIONS = 16,
  parameter int TIMER_BITS  = 26
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire tcte_pkg::cmd_t                    cmd,
  output logic                                   done,
  output tcte_pkg::result_t                      result,
  input  wire logic                              wr_en,
  input  wire logic [tcte_pkg::CFG_IDX_W-1:0]    wr_index,
  input  wire logic [tcte_pkg::CFG_BITS-1:0]     wr_data
);

  localparam int AW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
  localparam int EW = 3 * TIMER_BITS + 5;

  localparam logic ST_CLEAR = 1'b0;
  localparam logic ST_RUN   = 1'b1;

  logic              state;
  logic [AW-1:0]     clr_addr;
  tcte_pkg::cfg_t    cfg;

  logic              accept;
  logic [AW-1:0]     in_idx;
  logic              in_table;

  logic              s1_valid;
  tcte_pkg::cmd_t    s1_cmd;
  logic [AW-1:0]     s1_idx;
  logic              s1_in_table;
  logic              fwd_hit;
  logic [EW-1:0]     fwd_entry;

  logic [EW-1:0]     rd_data;
  logic [EW-1:0]     cur_entry;
  logic [EW-1:0]     entry_next;
  tcte_pkg::result_t upd_res;

  logic              tbl_we;
  logic [AW-1:0]     tbl_waddr;
  logic [EW-1:0]     tbl_wdata;
  logic              s1_write;

  assign busy     = (state == ST_CLEAR);
  assign accept   = start && !busy;
  assign in_idx   = AW'(cmd.conn);
  assign in_table = 32'(cmd.conn) < CONNECTIONS;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timewait_limit     <= tcte_pkg::TIMEWAIT_LIMIT_RST;
      cfg.retrans_initial    <= tcte_pkg::RETRANS_INITIAL_RST;
      cfg.scan_interval      <= tcte_pkg::SCAN_INTERVAL_RST;
      cfg.max_retries        <= tcte_pkg::MAX_RETRIES_RST;
      cfg.segment_size_limit <= tcte_pkg::SEGMENT_LIMIT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        tcte_pkg::REG_TIMEWAIT_LIMIT:  cfg.timewait_limit     <= wr_data;
        tcte_pkg::REG_RETRANS_INITIAL: cfg.retrans_initial    <= wr_data;
        tcte_pkg::REG_SCAN_INTERVAL:   cfg.scan_interval      <= wr_data;
        tcte_pkg::REG_MAX_RETRIES:     cfg.max_retries        <= wr_data[1:0];
        tcte_pkg::REG_SEGMENT_LIMIT:   cfg.segment_size_limit <= wr_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      if (clr_addr == AW'(CONNECTIONS - 1)) begin
        state <= ST_RUN;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  assign s1_write  = s1_valid && s1_in_table;
  assign tbl_we    = busy || s1_write;
  assign tbl_waddr = busy ? clr_addr : s1_idx;
  assign tbl_wdata = busy ? '0 : entry_next;

  tcte_table #(
    .DEPTH (CONNECTIONS),
    .WIDTH (EW),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (tbl_waddr),
    .wr_data (tbl_wdata),
    .rd_addr (in_idx),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      s1_valid <= accept;
      fwd_hit  <= accept && s1_write && (s1_idx == in_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd      <= cmd;
      s1_idx      <= in_idx;
      s1_in_table <= in_table;
    end
    fwd_entry <= entry_next;
  end

  assign cur_entry = fwd_hit ? fwd_entry : rd_data;

  tcte_update #(
    .TIMER_BITS (TIMER_BITS)
  ) u_update (
    .cfg        (cfg),
    .cmd        (s1_cmd),
    .entry      (cur_entry),
    .entry_next (entry_next),
    .res        (upd_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      if (s1_in_table) begin
        result <= upd_res;
      end else begin
        result <= '{conn_out:        s1_cmd.conn,
                    timewait_closed: 1'b0,
                    retrans_action:  tcte_pkg::RT_NONE,
                    persist_action:  tcte_pkg::PS_NONE,
                    retry_count:     2'd0};
      end
    end
  end

endmodule

`default_nettype wire
